// File: hw/rtl/guillotine_rect_packer_top_defines.svh
// Assertion macros for the packer checker
`ifndef GUILLOTINE_RECT_PACKER_TOP_DEFINES_SVH
`define GUILLOTINE_RECT_PACKER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define GRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define GRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/grp_pkg.sv
// Shared constants, codes and types of the guillotine rectangle packer
package grp_pkg;

    localparam int MAX_SPACES    = 64;
    localparam int COORD_BITS    = 16;
    localparam int SIZE_BITS     = COORD_BITS + 1;
    localparam int IDX_BITS      = $clog2(MAX_SPACES);
    localparam int CNT_BITS      = $clog2(MAX_SPACES + 1);

    localparam int RECT_BITS     = 16;
    localparam int PAD_BITS      = 10;
    localparam int ATLAS_BITS    = 16;
    localparam int POS_BITS      = 16;
    localparam int STATUS_BITS   = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // padded size: 16-bit size plus twice a 10-bit margin
    localparam int PW_BITS   = RECT_BITS + 1;
    localparam int CMP_BITS  = (SIZE_BITS > PW_BITS) ? SIZE_BITS : PW_BITS;
    localparam int SUM_BITS  = ((COORD_BITS > CMP_BITS) ? COORD_BITS : CMP_BITS) + 1;
    localparam int AREA_BITS = 2 * SIZE_BITS;

    localparam logic [STATUS_BITS-1:0] ST_PLACED   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PADDING      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATLAS_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATLAS_HEIGHT = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SIZE_BITS-1:0]  w;
        logic [SIZE_BITS-1:0]  h;
    } t_space;

endpackage

// File: hw/rtl/guillotine_rect_packer_top.sv
// Guillotine rectangle packer: free-space list, backward scan and split sequencer
//
// Usage: pulse start with new_pack, rect_w and rect_h while busy is low; the
// request is taken at that edge and busy rises on the next cycle. One result
// (pos_x, pos_y, status) follows on o_done for exactly one cycle; the receiver
// cannot stall it and must take it then. Status 0 placed, 1 no fit, 2 list
// overflow; on a failure the positions read zero and the free list is kept
// as it stands after any new_pack reset. Configuration (padding, atlas width,
// atlas height) is written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the
// user must write it only while busy is low, which the block itself does not
// enforce; unknown indexes dropped. With new_pack the list is first reset to one
// space covering the atlas. The list is scanned from the last entry down, at
// most 64 entries: the single read port of the free-list memory delivers one
// entry per cycle to the fit compare. A shared 17x17 multiplier then computes
// the right and then the down split area, and the one write port takes the swap and
// up to two appends. A miss, an overflow or an empty list ends the request with its
// failure status; the next request may be taken at the edge that takes the result.
// Reset (synchronous) empties the list and restores padding 0 and a
// 1024x1024 atlas; the memory itself is not cleared.
module guillotine_rect_packer_top
    import grp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_new_pack,
    input  logic [RECT_BITS-1:0]     i_rect_w,
    input  logic [RECT_BITS-1:0]     i_rect_h,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output logic                     o_done,
    output logic [POS_BITS-1:0]      o_pos_x,
    output logic [POS_BITS-1:0]      o_pos_y,
    output logic [STATUS_BITS-1:0]   o_status
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_MULR   = 4'd5;
    localparam logic [3:0] S_MULD   = 4'd6;
    localparam logic [3:0] S_SWAPRD = 4'd7;
    localparam logic [3:0] S_SWAPWR = 4'd8;
    localparam logic [3:0] S_PUSH1  = 4'd9;
    localparam logic [3:0] S_PUSH2  = 4'd10;

    // configuration
    logic [PAD_BITS-1:0]   r_pad;
    logic [ATLAS_BITS-1:0] r_atlas_w;
    logic [ATLAS_BITS-1:0] r_atlas_h;

    // control
    logic [3:0]          r_state;
    logic [CNT_BITS-1:0] r_count;
    logic [IDX_BITS-1:0] r_idx;
    logic                r_issue;
    logic [IDX_BITS-1:0] r_cand;
    logic                r_cand_v;

    // working item
    logic [PW_BITS-1:0]   r_pw;
    logic [PW_BITS-1:0]   r_ph;
    t_space               r_cur;
    logic [IDX_BITS-1:0]  r_found;
    logic [SIZE_BITS-1:0] r_rw;
    logic [SIZE_BITS-1:0] r_dh;
    logic                 r_has_r;
    logic                 r_has_d;
    logic [AREA_BITS-1:0] r_area_r;
    logic [AREA_BITS-1:0] r_area_d;

    // result
    logic                   r_done;
    logic [POS_BITS-1:0]    r_pos_x;
    logic [POS_BITS-1:0]    r_pos_y;
    logic [STATUS_BITS-1:0] r_status;

    // free-list memory
    t_space              r_mem [MAX_SPACES];
    t_space              r_rdata;
    logic                mem_re;
    logic [IDX_BITS-1:0] mem_raddr;
    logic                mem_we;
    logic [IDX_BITS-1:0] mem_waddr;
    t_space              mem_wdata;

    logic                 scan_fit;
    logic [IDX_BITS-1:0]  last_idx;
    logic [CNT_BITS:0]    need;
    logic                 has_r;
    logic                 has_d;
    logic                 right_first;
    t_space               piece_r;
    t_space               piece_d;
    t_space               piece_first;
    t_space               piece_second;
    logic [SIZE_BITS-1:0] mul_a;
    logic [SIZE_BITS-1:0] mul_b;
    logic [AREA_BITS-1:0] mul_p;
    logic [SUM_BITS-1:0]  place_x;
    logic [SUM_BITS-1:0]  place_y;

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_pos_x  = r_pos_x;
    assign o_pos_y  = r_pos_y;
    assign o_status = r_status;

    assign last_idx = IDX_BITS'(r_count - CNT_BITS'(1));

    assign scan_fit = r_cand_v
                   && (CMP_BITS'(r_pw) <= CMP_BITS'(r_rdata.w))
                   && (CMP_BITS'(r_ph) <= CMP_BITS'(r_rdata.h));

    assign has_r = (CMP_BITS'(r_cur.w) != CMP_BITS'(r_pw));
    assign has_d = (CMP_BITS'(r_cur.h) != CMP_BITS'(r_ph));
    assign need  = (CNT_BITS+1)'(r_count) + (CNT_BITS+1)'(has_r) + (CNT_BITS+1)'(has_d);

    always_comb begin
        piece_r.x = COORD_BITS'(SUM_BITS'(r_cur.x) + SUM_BITS'(r_pw));
        piece_r.y = r_cur.y;
        piece_r.w = r_rw;
        piece_r.h = SIZE_BITS'(r_ph);
        piece_d.x = r_cur.x;
        piece_d.y = COORD_BITS'(SUM_BITS'(r_cur.y) + SUM_BITS'(r_ph));
        piece_d.w = r_cur.w;
        piece_d.h = r_dh;
    end

    // larger right piece goes first; ties favor the down piece
    assign right_first  = r_has_r && (!r_has_d || (r_area_r > r_area_d));
    assign piece_first  = right_first ? piece_r : piece_d;
    assign piece_second = right_first ? piece_d : piece_r;

    // shared multiplier for the two split areas
    always_comb begin
        if (r_state == S_MULD) begin
            mul_a = r_cur.w;
            mul_b = r_dh;
        end else begin
            mul_a = r_rw;
            mul_b = SIZE_BITS'(r_ph);
        end
    end
    assign mul_p = AREA_BITS'(mul_a) * AREA_BITS'(mul_b);

    assign place_x = SUM_BITS'(r_cur.x) + SUM_BITS'(r_pad);
    assign place_y = SUM_BITS'(r_cur.y) + SUM_BITS'(r_pad);

    // memory port control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        mem_we    = 1'b0;
        mem_waddr = r_found;
        mem_wdata = r_rdata;
        unique case (r_state)
            S_SCAN: begin
                mem_re = r_issue && !scan_fit;
            end
            S_SWAPRD: begin
                mem_re    = 1'b1;
                mem_raddr = last_idx;
            end
            S_INIT: begin
                mem_we      = 1'b1;
                mem_waddr   = '0;
                mem_wdata.x = '0;
                mem_wdata.y = '0;
                mem_wdata.w = SIZE_BITS'(r_atlas_w);
                mem_wdata.h = SIZE_BITS'(r_atlas_h);
            end
            S_SWAPWR: begin
                mem_we = 1'b1;
            end
            S_PUSH1: begin
                mem_we    = r_has_r || r_has_d;
                mem_waddr = IDX_BITS'(r_count);
                mem_wdata = piece_first;
            end
            S_PUSH2: begin
                mem_we    = 1'b1;
                mem_waddr = IDX_BITS'(r_count);
                mem_wdata = piece_second;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad     <= '0;
            r_atlas_w <= ATLAS_BITS'(1024);
            r_atlas_h <= ATLAS_BITS'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PADDING:      r_pad     <= i_cfg_wdata[PAD_BITS-1:0];
                CFG_ATLAS_WIDTH:  r_atlas_w <= ATLAS_BITS'(i_cfg_wdata);
                CFG_ATLAS_HEIGHT: r_atlas_h <= ATLAS_BITS'(i_cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_issue  <= 1'b0;
            r_cand_v <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_pw       <= PW_BITS'(i_rect_w) + PW_BITS'({r_pad, 1'b0});
                        r_ph       <= PW_BITS'(i_rect_h) + PW_BITS'({r_pad, 1'b0});
                        r_state    <= i_new_pack ? S_INIT : S_START;
                    end
                end
                S_INIT: begin
                    r_count <= CNT_BITS'(1);
                    r_state <= S_START;
                end
                S_START: begin
                    if (r_count == '0) begin
                        r_done   <= 1'b1;
                        r_status <= ST_NO_FIT;
                        r_pos_x  <= '0;
                        r_pos_y  <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx    <= last_idx;
                        r_issue  <= 1'b1;
                        r_cand_v <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_fit) begin
                        r_cur    <= r_rdata;
                        r_found  <= r_cand;
                        r_issue  <= 1'b0;
                        r_cand_v <= 1'b0;
                        r_state  <= S_CHECK;
                    end else if (r_issue) begin
                        r_cand   <= r_idx;
                        r_cand_v <= 1'b1;
                        if (r_idx == '0) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx - IDX_BITS'(1);
                        end
                    end else if (r_cand_v) begin
                        // the first entry missed too
                        r_cand_v <= 1'b0;
                        r_done   <= 1'b1;
                        r_status <= ST_NO_FIT;
                        r_pos_x  <= '0;
                        r_pos_y  <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                S_CHECK: begin
                    r_has_r <= has_r;
                    r_has_d <= has_d;
                    r_rw    <= SIZE_BITS'(CMP_BITS'(r_cur.w) - CMP_BITS'(r_pw));
                    r_dh    <= SIZE_BITS'(CMP_BITS'(r_cur.h) - CMP_BITS'(r_ph));
                    if (need > (CNT_BITS+1)'(MAX_SPACES + 1)) begin
                        r_done   <= 1'b1;
                        r_status <= ST_OVERFLOW;
                        r_pos_x  <= '0;
                        r_pos_y  <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_MULR;
                    end
                end
                S_MULR: begin
                    r_area_r <= mul_p;
                    r_state  <= S_MULD;
                end
                S_MULD: begin
                    r_area_d <= mul_p;
                    r_state  <= S_SWAPRD;
                end
                S_SWAPRD: begin
                    r_state <= S_SWAPWR;
                end
                S_SWAPWR: begin
                    // last entry fills the hole, then drop the count
                    r_count <= r_count - CNT_BITS'(1);
                    r_state <= S_PUSH1;
                end
                S_PUSH1: begin
                    if (r_has_r || r_has_d) begin
                        r_count <= r_count + CNT_BITS'(1);
                    end
                    if (r_has_r && r_has_d) begin
                        r_state <= S_PUSH2;
                    end else begin
                        r_done   <= 1'b1;
                        r_status <= ST_PLACED;
                        r_pos_x  <= POS_BITS'(place_x);
                        r_pos_y  <= POS_BITS'(place_y);
                        r_state  <= S_IDLE;
                    end
                end
                S_PUSH2: begin
                    r_count  <= r_count + CNT_BITS'(1);
                    r_done   <= 1'b1;
                    r_status <= ST_PLACED;
                    r_pos_x  <= POS_BITS'(place_x);
                    r_pos_y  <= POS_BITS'(place_y);
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/grp_checker.sv
// Port-level checker for the packer, bound to the top level
`include "guillotine_rect_packer_top_defines.svh"

module grp_checker
    import grp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_done,
    input logic [POS_BITS-1:0]    o_pos_x,
    input logic [POS_BITS-1:0]    o_pos_y,
    input logic [STATUS_BITS-1:0] o_status
);

    `GRP_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request not taken")
    `GRP_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result held over a cycle")
    `GRP_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")
    `GRP_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && (o_status != ST_PLACED), (o_pos_x == '0) && (o_pos_y == '0), "failed placement with nonzero position")

endmodule

bind guillotine_rect_packer_top grp_checker u_grp_checker (.*);

// File: tb/guillotine_rect_packer_top_tb.sv
// Self-checking testbench for the guillotine rectangle packer with a built-in free-list predictor
module guillotine_rect_packer_top_tb;
    import grp_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic                 new_pack;
        logic [RECT_BITS-1:0] rect_w;
        logic [RECT_BITS-1:0] rect_h;
        logic                 drain;
    } t_rect_req;

    typedef struct packed {
        logic [POS_BITS-1:0]    pos_x;
        logic [POS_BITS-1:0]    pos_y;
        logic [STATUS_BITS-1:0] status;
    } t_placement;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_new_pack = 1'b0;
    logic [RECT_BITS-1:0]     i_rect_w = '0;
    logic [RECT_BITS-1:0]     i_rect_h = '0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;
    logic                     o_done;
    logic [POS_BITS-1:0]      o_pos_x;
    logic [POS_BITS-1:0]      o_pos_y;
    logic [STATUS_BITS-1:0]   o_status;

    guillotine_rect_packer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_new_pack  (i_new_pack),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: configuration copy and free-space list
    logic [PAD_BITS-1:0]   pad_q = '0;
    logic [ATLAS_BITS-1:0] aw_q = 16'd1024;
    logic [ATLAS_BITS-1:0] ah_q = 16'd1024;
    t_space                free_space [MAX_SPACES];
    int                    free_cnt = 0;

    t_rect_req  rect_pending_q [$];
    t_placement placement_q [$];
    int         n_sent = 0;
    int         n_recv = 0;
    int         errors = 0;
    int         idle_pct = 0;

    function automatic void push_free(logic [31:0] x, logic [31:0] y,
                                      logic [31:0] w, logic [31:0] h);
        if (free_cnt < MAX_SPACES) begin
            free_space[free_cnt].x = x[COORD_BITS-1:0];
            free_space[free_cnt].y = y[COORD_BITS-1:0];
            free_space[free_cnt].w = w[SIZE_BITS-1:0];
            free_space[free_cnt].h = h[SIZE_BITS-1:0];
            free_cnt++;
        end
    endfunction

    function automatic t_placement place_rect(logic np, logic [RECT_BITS-1:0] rw,
                                              logic [RECT_BITS-1:0] rh);
        t_placement  r;
        logic [31:0] pw, ph, cx, cy, cw, ch;
        logic [63:0] area_rt, area_dn;
        int          hit, pieces, i;
        r.pos_x  = '0;
        r.pos_y  = '0;
        r.status = ST_NO_FIT;
        if (np) begin
            free_cnt = 0;
            push_free(0, 0, aw_q, ah_q);
        end
        pw = rw + 2 * pad_q;
        ph = rh + 2 * pad_q;
        // scan from the newest space down, take the first that fits
        hit = -1;
        i = free_cnt - 1;
        while (i >= 0 && hit < 0) begin
            if (pw <= free_space[i].w && ph <= free_space[i].h)
                hit = i;
            i--;
        end
        if (hit < 0)
            return r;
        cx = free_space[hit].x;
        cy = free_space[hit].y;
        cw = free_space[hit].w;
        ch = free_space[hit].h;
        pieces = int'(cw != pw) + int'(ch != ph);
        if (free_cnt - 1 + pieces > MAX_SPACES) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        free_space[hit] = free_space[free_cnt-1];
        free_cnt--;
        if (cw != pw && ch == ph) begin
            push_free(cx + pw, cy, cw - pw, ch);
        end else if (cw == pw && ch != ph) begin
            push_free(cx, cy + ph, cw, ch - ph);
        end else if (cw != pw && ch != ph) begin
            area_rt = (cw - pw) * ph;
            area_dn = cw * (ch - ph);
            // larger piece goes in first, ties favor the down piece
            if (area_rt > area_dn) begin
                push_free(cx + pw, cy, cw - pw, ph);
                push_free(cx, cy + ph, cw, ch - ph);
            end else begin
                push_free(cx, cy + ph, cw, ch - ph);
                push_free(cx + pw, cy, cw - pw, ph);
            end
        end
        r.pos_x  = 16'(cx + pad_q);
        r.pos_y  = 16'(cy + pad_q);
        r.status = ST_PLACED;
        return r;
    endfunction

    // driver: present the oldest pending request, idling at random and holding a drain request until every result is in
    always @(posedge i_clk) begin : drive
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                placement_q.push_back(place_rect(i_new_pack, i_rect_w, i_rect_h));
                void'(rect_pending_q.pop_front());
                n_sent++;
            end
            if (rect_pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                !(rect_pending_q[0].drain && n_sent != n_recv)) begin
                start      <= 1'b1;
                i_new_pack <= rect_pending_q[0].new_pack;
                i_rect_w   <= rect_pending_q[0].rect_w;
                i_rect_h   <= rect_pending_q[0].rect_h;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each result against the oldest prediction
    always @(posedge i_clk) begin : check
        t_placement want;
        if (i_rst_n && o_done) begin
            if (placement_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d status=%0d",
                         $time, o_pos_x, o_pos_y, o_status);
                errors++;
            end else begin
                want = placement_q.pop_front();
                n_recv <= n_recv + 1;
                if (o_pos_x !== want.pos_x) begin
                    $display("%0t: pos_x expected %0d got %0d", $time, want.pos_x, o_pos_x);
                    errors++;
                end
                if (o_pos_y !== want.pos_y) begin
                    $display("%0t: pos_y expected %0d got %0d", $time, want.pos_y, o_pos_y);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, o_status);
                    errors++;
                end
            end
        end
    end

    task automatic add_req(logic np, logic [RECT_BITS-1:0] w, logic [RECT_BITS-1:0] h,
                           logic drain);
        t_rect_req r;
        r.new_pack = np;
        r.rect_w   = w;
        r.rect_h   = h;
        r.drain    = drain;
        rect_pending_q.push_back(r);
    endtask

    // wait until every request is taken, every result is in and the block is idle
    task automatic settle();
        @(negedge i_clk);
        while (rect_pending_q.size() != 0 || n_recv != n_sent || busy)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_PADDING:      pad_q = data[PAD_BITS-1:0];
            CFG_ATLAS_WIDTH:  aw_q  = data;
            CFG_ATLAS_HEIGHT: ah_q  = data;
            default: ;
        endcase
    endtask

    task automatic configure(logic [CFG_DATA_BITS-1:0] pad, logic [CFG_DATA_BITS-1:0] aw,
                             logic [CFG_DATA_BITS-1:0] ah);
        settle();
        write_reg(CFG_PADDING, pad);
        write_reg(CFG_ATLAS_WIDTH, aw);
        write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(CFG_ATLAS_HEIGHT, ah);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [RECT_BITS-1:0] pick_dim(int unsigned span, bit tiny);
        int unsigned room;
        room = (span > 2 * pad_q) ? span - 2 * pad_q : 0;
        if (tiny)
            return RECT_BITS'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0:       return RECT_BITS'($urandom);
            1:       return RECT_BITS'(room);
            2, 3:    return RECT_BITS'($urandom_range(0, room));
            default: return RECT_BITS'($urandom_range(0, room / 8));
        endcase
    endfunction

    // packs: a new_pack request then placements, or short runs with random new_pack; long tiny packs fill the list
    task automatic add_random(int unsigned total);
        int unsigned made, len, kind, k;
        bit          tiny;
        logic        np;
        logic [RECT_BITS-1:0] w, h;
        made = 0;
        while (made < total) begin
            kind = (made == 0 && total >= 90) ? 6 : $urandom_range(0, 9);
            if (kind < 6)
                len = $urandom_range(2, 30);
            else if (kind == 6)
                len = 90;
            else
                len = $urandom_range(1, 4);
            for (k = 0; k < len; k++) begin
                np   = (kind < 7) ? (k == 0) : 1'($urandom_range(0, 1));
                tiny = (kind == 6) || (kind < 6 && $urandom_range(0, 3) == 0);
                w    = pick_dim(aw_q, tiny);
                h    = pick_dim(ah_q, tiny);
                if (kind >= 7 && $urandom_range(0, 1) == 1) begin
                    w = RECT_BITS'($urandom);
                    h = RECT_BITS'($urandom);
                end
                add_req(np, w, h, k == 0 && $urandom_range(0, 7) == 0);
            end
            made += len;
        end
    endtask

    initial begin : stim
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: no padding, 1024 x 1024 atlas
        idle_pct = 0;
        add_req(1'b0, 16'd1, 16'd1, 1'b0);          // empty list after reset
        add_req(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);    // list reset holds despite miss
        add_req(1'b0, 16'd0, 16'd0, 1'b0);
        add_req(1'b1, 16'd1024, 16'd1024, 1'b0);    // exact fit
        add_req(1'b0, 16'd0, 16'd0, 1'b0);
        add_req(1'b1, 16'd1024, 16'd10, 1'b0);      // down piece only
        add_req(1'b1, 16'd10, 16'd1024, 1'b0);      // right piece only
        add_req(1'b1, 16'd10, 16'd1000, 1'b0);      // right piece larger
        add_req(1'b1, 16'd0, 16'd512, 1'b0);        // equal areas
        add_req(1'b1, 16'd1000, 16'd10, 1'b0);
        add_req(1'b0, 16'd5, 16'd7, 1'b0);
        add_req(1'b0, 16'd100, 16'd3, 1'b0);
        add_req(1'b0, 16'd1025, 16'd1, 1'b0);
        add_req(1'b1, 16'h5555, 16'h02AA, 1'b0);
        add_req(1'b1, 16'd300, 16'd200, 1'b1);
        add_req(1'b0, 16'd300, 16'd200, 1'b0);
        add_req(1'b0, 16'd300, 16'd200, 1'b0);
        add_req(1'b0, 16'd424, 16'd1024, 1'b0);
        add_req(1'b0, 16'hFFFF, 16'd0, 1'b0);
        add_req(1'b0, 16'd0, 16'hFFFF, 1'b0);

        configure(16'hFC00, 16'd0, 16'd7);          // upper padding bits dropped, zero width
        add_req(1'b1, 16'd0, 16'd0, 1'b0);
        add_req(1'b0, 16'd1, 16'd0, 1'b0);
        add_req(1'b1, 16'd0, 16'd7, 1'b0);

        configure(16'd2, 16'd256, 16'd128);
        idle_pct = 0;
        add_random(150);

        configure(16'd0, 16'hFFFF, 16'hFFFF);
        idle_pct = 85;
        add_random(150);

        configure(16'd1023, 16'hFFFF, 16'd4096);
        idle_pct = 23;
        add_random(120);

        configure(16'd0, 16'd1, 16'd1);
        idle_pct = 0;
        add_random(30);

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && placement_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
